FILE: design/vau_pkg.sv
// vau_pkg: shared types and constants for the vertex attribute unpack block
// format codes, number formats, endian modes and the per-lane work descriptor
// no dependencies
package vau_pkg;

   // fp32 constants
   localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
   localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
   localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;

   // vertex data format codes
   localparam logic [5:0] FMT_8888    = 6'd6;
   localparam logic [5:0] FMT_2101010 = 6'd7;
   localparam logic [5:0] FMT_111110  = 6'd16;
   localparam logic [5:0] FMT_101111  = 6'd17;
   localparam logic [5:0] FMT_16_16   = 6'd25;
   localparam logic [5:0] FMT_16X4    = 6'd26;
   localparam logic [5:0] FMT_HALF2   = 6'd31;
   localparam logic [5:0] FMT_HALF4   = 6'd32;
   localparam logic [5:0] FMT_F32X1   = 6'd36;
   localparam logic [5:0] FMT_F32X2   = 6'd37;
   localparam logic [5:0] FMT_F32X4   = 6'd38;
   localparam logic [5:0] FMT_F32X3   = 6'd57;

   // number formats
   localparam logic [1:0] NF_UNORM = 2'd0;
   localparam logic [1:0] NF_SNORM = 2'd1;
   localparam logic [1:0] NF_SINT  = 2'd2;
   localparam logic [1:0] NF_UINT  = 2'd3;

   // endian modes
   localparam logic [1:0] ENDIAN_NONE   = 2'd0;
   localparam logic [1:0] ENDIAN_SWAP16 = 2'd1;

   // how one lane converts its field
   typedef enum logic [2:0] {
      LK_RAW,
      LK_HALF,
      LK_UINT,
      LK_SINT,
      LK_UNORM,
      LK_SNORM
   } lane_kind_type;

   // work descriptor for one component lane
   typedef struct packed {
      lane_kind_type kind;
      logic [4:0]    nbits;
      logic [31:0]   raw;
   } lane_in_type;

endpackage

FILE: design/vau_req_if.sv
// vau_req_if: request channel of the vertex attribute unpack block
// valid/ready handshake with the raw attribute bytes and their description
// no dependencies
interface vau_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_low;
   logic [63:0] data_high;
   logic [5:0]  format_code;
   logic [1:0]  number_format;
   logic [1:0]  endian_mode;
   logic [11:0] attr_offset;
   logic [4:0]  attr_len;
   logic [11:0] vertex_len;

   modport source (
      output valid, data_low, data_high, format_code, number_format,
      output endian_mode, attr_offset, attr_len, vertex_len,
      input  ready
   );
   modport sink (
      input  valid, data_low, data_high, format_code, number_format,
      input  endian_mode, attr_offset, attr_len, vertex_len,
      output ready
   );
endinterface

FILE: design/vau_rsp_if.sv
// vau_rsp_if: result channel of the vertex attribute unpack block
// valid/ready handshake with the four fp32 components and the ok flag
// no dependencies
interface vau_rsp_if;
   logic        valid;
   logic        ready;
   logic        decoded_ok;
   logic [31:0] comp_x;
   logic [31:0] comp_y;
   logic [31:0] comp_z;
   logic [31:0] comp_w;

   modport source (
      output valid, decoded_ok, comp_x, comp_y, comp_z, comp_w,
      input  ready
   );
   modport sink (
      input  valid, decoded_ok, comp_x, comp_y, comp_z, comp_w,
      output ready
   );
endinterface

FILE: design/vertex_attribute_unpack.sv
// vertex_attribute_unpack: top level, decode front end, four conversion lanes, merge
// depends on vau_pkg, vau_req_if, vau_rsp_if, vau_unpack, vau_lane
//
// usage
//   req_chan carries one vertex attribute per request: 16 raw bytes, format
//   code, number format, endian mode and the offset/size/vertex length used
//   for the bounds check. rsp_chan returns one result per request: four fp32
//   components (default 0,0,0,1) and decoded_ok.
//   rsp_chan.valid rises once the request has passed the three pipeline
//   registers, the first loaded at the accepting edge: decoded lane
//   descriptors, lane fraction stage and the output register after the lane
//   normalize/round step. a new request is taken every cycle unless the
//   output register holds an undelivered result that the receiver stalls.
//   the four lanes convert the components side by side; the merge stage
//   registers them with the ok flag.
//   reset clears all valid bits; the payload registers are not reset.
//   when the receiver stalls, the whole pipeline holds and req_chan.ready
//   drops only while an undelivered result sits in the output register and
//   rsp_chan.ready is low.
module vertex_attribute_unpack
   import vau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   vau_req_if.sink      req_chan,
   vau_rsp_if.source    rsp_chan
);

   logic         adv;
   logic         dec_ok;
   lane_in_type  dec_lanes [4];
   lane_in_type  lanes_ff [4];
   logic [31:0]  lane_comp [4];
   logic [31:0]  comp_ff [4];
   logic         valid1_ff, valid1_in;
   logic         valid2_ff, valid2_in;
   logic         out_valid_ff, out_valid_in;
   logic         ok1_ff, ok2_ff, ok_out_ff;

   // pipeline advances whenever the output slot is free or being taken
   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   vau_unpack u_unpack (
      .data_low      (req_chan.data_low),
      .data_high     (req_chan.data_high),
      .format_code   (req_chan.format_code),
      .number_format (req_chan.number_format),
      .endian_mode   (req_chan.endian_mode),
      .attr_offset   (req_chan.attr_offset),
      .attr_len      (req_chan.attr_len),
      .vertex_len    (req_chan.vertex_len),
      .ok            (dec_ok),
      .lanes         (dec_lanes)
   );

   // conversion lanes
   for (genvar g = 0; g < 4; g++) begin : g_lane
      vau_lane u_lane (
         .clock   (clock),
         .en      (adv),
         .lane_in (lanes_ff[g]),
         .comp    (lane_comp[g])
      );
   end

   // valid chain
   always_comb begin
      valid1_in    = adv ? (req_chan.valid && req_chan.ready) : valid1_ff;
      valid2_in    = adv ? valid1_ff : valid2_ff;
      out_valid_in = adv ? valid2_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid1_ff    <= valid1_in;
         valid2_ff    <= valid2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers and merge
   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff  <= dec_lanes;
         ok1_ff    <= dec_ok;
         ok2_ff    <= ok1_ff;
         ok_out_ff <= ok2_ff;
         comp_ff   <= lane_comp;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.decoded_ok = ok_out_ff;
   assign rsp_chan.comp_x     = comp_ff[0];
   assign rsp_chan.comp_y     = comp_ff[1];
   assign rsp_chan.comp_z     = comp_ff[2];
   assign rsp_chan.comp_w     = comp_ff[3];

   // a rejected attribute always carries the default components
   a_reject_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.decoded_ok) |->
      (rsp_chan.comp_x == FP_ZERO && rsp_chan.comp_y == FP_ZERO &&
       rsp_chan.comp_z == FP_ZERO && rsp_chan.comp_w == FP_ONE))
      else $error("rejected attribute with non-default components");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   // a stalled pipeline keeps its in-flight requests
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!adv && valid1_ff && valid2_ff) |=> (valid1_ff && valid2_ff))
      else $error("in-flight request lost during stall");

endmodule

FILE: design/vau_unpack.sv
// vau_unpack: byte swap, bounds check and format decode into four lane descriptors
// depends on vau_pkg
module vau_unpack
   import vau_pkg::*;
(
   input  logic [63:0]  data_low,
   input  logic [63:0]  data_high,
   input  logic [5:0]   format_code,
   input  logic [1:0]   number_format,
   input  logic [1:0]   endian_mode,
   input  logic [11:0]  attr_offset,
   input  logic [4:0]   attr_len,
   input  logic [11:0]  vertex_len,
   output logic         ok,
   output lane_in_type  lanes [4]
);

   function automatic lane_kind_type nf_kind(input logic [1:0] nf);
      lane_kind_type k;
      unique case (nf)
         NF_UNORM: k = LK_UNORM;
         NF_SNORM: k = LK_SNORM;
         NF_SINT:  k = LK_SINT;
         default:  k = LK_UINT;
      endcase
      return k;
   endfunction

   always_comb begin
      logic [7:0]    b [16];
      logic [7:0]    s [16];
      logic [31:0]   w [4];
      logic [15:0]   h [4];
      logic [12:0]   span_end;
      logic          span_ok;
      logic          known;
      logic          is16;
      logic          unit2;
      logic          do_swap;
      lane_kind_type ik;

      // split into bytes
      for (int i = 0; i < 8; i++) begin
         b[i]     = data_low[8*i +: 8];
         b[i + 8] = data_high[8*i +: 8];
      end

      // span check
      span_end = {1'b0, attr_offset} + {8'b0, attr_len};
      span_ok  = (attr_len != 5'd0) && (span_end <= {1'b0, vertex_len});

      // swap unit: 2 bytes in ENDIAN_SWAP16 mode and for the 16-bit formats, else 4 bytes
      is16 = (format_code == FMT_16_16) || (format_code == FMT_16X4) ||
             (format_code == FMT_HALF2) || (format_code == FMT_HALF4);
      unit2   = (endian_mode == ENDIAN_SWAP16) || is16;
      do_swap = (endian_mode != ENDIAN_NONE) && (attr_len <= 5'd16);

      // reverse bytes within every whole unit inside the size
      for (int i = 0; i < 16; i++) begin
         if (unit2) begin
            s[i] = (do_swap && (5'((i | 1) + 1) <= attr_len)) ? b[i ^ 1] : b[i];
         end else begin
            s[i] = (do_swap && (5'((i | 3) + 1) <= attr_len)) ? b[i ^ 3] : b[i];
         end
      end

      for (int k = 0; k < 4; k++) begin
         w[k] = {s[4*k+3], s[4*k+2], s[4*k+1], s[4*k]};
         h[k] = {s[2*k+1], s[2*k]};
      end

      // default components
      for (int k = 0; k < 4; k++) begin
         lanes[k] = '{kind: LK_RAW, nbits: 5'd0, raw: FP_ZERO};
      end
      lanes[3].raw = FP_ONE;

      ik    = nf_kind(number_format);
      known = 1'b1;

      // format decode
      unique case (format_code)
         FMT_F32X1, FMT_F32X2, FMT_F32X3, FMT_F32X4: begin
            for (int k = 0; k < 4; k++) begin
               if ((k == 0) || (k == 1 && format_code != FMT_F32X1) ||
                   (k == 2 && (format_code == FMT_F32X3 || format_code == FMT_F32X4)) ||
                   (k == 3 && format_code == FMT_F32X4)) begin
                  lanes[k] = '{kind: LK_RAW, nbits: 5'd0, raw: w[k]};
               end
            end
         end
         FMT_HALF2, FMT_HALF4: begin
            for (int k = 0; k < 4; k++) begin
               if (k < 2 || format_code == FMT_HALF4) begin
                  lanes[k] = '{kind: LK_HALF, nbits: 5'd16, raw: {16'b0, h[k]}};
               end
            end
         end
         FMT_16_16, FMT_16X4: begin
            for (int k = 0; k < 4; k++) begin
               if (k < 2 || format_code == FMT_16X4) begin
                  lanes[k] = '{kind: ik, nbits: 5'd16, raw: {16'b0, h[k]}};
               end
            end
         end
         FMT_8888: begin
            for (int k = 0; k < 4; k++) begin
               lanes[k] = '{kind: ik, nbits: 5'd8, raw: {24'b0, w[0][8*k +: 8]}};
            end
         end
         FMT_2101010: begin
            for (int k = 0; k < 3; k++) begin
               lanes[k] = '{kind: ik, nbits: 5'd10, raw: {22'b0, w[0][10*k +: 10]}};
            end
            lanes[3] = '{kind: ik, nbits: 5'd2, raw: {30'b0, w[0][31:30]}};
         end
         FMT_111110: begin
            lanes[0] = '{kind: LK_UNORM, nbits: 5'd11, raw: {21'b0, w[0][10:0]}};
            lanes[1] = '{kind: LK_UNORM, nbits: 5'd11, raw: {21'b0, w[0][21:11]}};
            lanes[2] = '{kind: LK_UNORM, nbits: 5'd10, raw: {22'b0, w[0][31:22]}};
         end
         FMT_101111: begin
            lanes[0] = '{kind: LK_UNORM, nbits: 5'd10, raw: {22'b0, w[0][9:0]}};
            lanes[1] = '{kind: LK_UNORM, nbits: 5'd11, raw: {21'b0, w[0][20:10]}};
            lanes[2] = '{kind: LK_UNORM, nbits: 5'd11, raw: {21'b0, w[0][31:21]}};
         end
         default: known = 1'b0;
      endcase

      // rejected attributes keep the defaults
      ok = span_ok && known;
      if (!ok) begin
         for (int k = 0; k < 4; k++) begin
            lanes[k] = '{kind: LK_RAW, nbits: 5'd0, raw: FP_ZERO};
         end
         lanes[3].raw = FP_ONE;
      end
   end

endmodule

FILE: design/vau_lane.sv
// vau_lane: converts one component field to fp32 in two steps
// first step prepares sign, magnitude and fraction bits, second normalizes and rounds
// depends on vau_pkg
module vau_lane
   import vau_pkg::*;
(
   input  logic         clock,
   input  logic         en,
   input  lane_in_type  lane_in,
   output logic [31:0]  comp
);

   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        neg;
      logic [7:0]  ebase;
      logic [63:0] frac;
   } lane_mid_type;

   lane_mid_type mid_in, mid_ff;

   // step one: field to sign, magnitude and left-aligned fraction
   always_comb begin
      logic [16:0] mask;
      logic [16:0] field;
      logic [16:0] top_bits;
      logic [16:0] mag;
      logic [16:0] dmax;
      logic [4:0]  p;
      logic        neg;
      logic        signed_k;
      logic [63:0] r;
      logic        hs;
      logic [4:0]  he;
      logic [9:0]  hm;
      logic [3:0]  hk;
      logic [3:0]  hsh;
      logic [9:0]  hmn;
      logic [7:0]  hexp;

      mask     = (17'd1 << lane_in.nbits) - 17'd1;
      field    = lane_in.raw[16:0] & mask;
      signed_k = (lane_in.kind == LK_SINT) || (lane_in.kind == LK_SNORM);
      top_bits = field >> (lane_in.nbits - 5'd1);
      neg      = signed_k && top_bits[0];
      mag      = neg ? ((17'd1 << lane_in.nbits) - field) : field;
      p        = (lane_in.kind == LK_SNORM) ? (lane_in.nbits - 5'd1) : lane_in.nbits;
      dmax     = (17'd1 << p) - 17'd1;

      // repeating binary expansion of mag / (2^p - 1)
      r = {mag[15:0], 48'b0} << (5'd16 - p);
      for (int s = 0; s < 6; s++) begin
         r = r | (r >> (11'(p) << s));
      end

      // half fields
      hs  = lane_in.raw[15];
      he  = lane_in.raw[14:10];
      hm  = lane_in.raw[9:0];
      hk  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (hm[i]) hk = 4'(i);
      end
      hsh  = 4'd10 - hk;
      hmn  = 10'(hm << hsh);
      hexp = 8'd113 - {4'b0, hsh};

      mid_in = '{special: 1'b1, special_val: FP_ZERO, neg: neg, ebase: 8'd0, frac: 64'b0};
      case (lane_in.kind)
         LK_HALF: begin
            if (he == 5'd0) begin
               mid_in.special_val = (hm == 10'd0) ? {hs, 31'b0} : {hs, hexp, hmn, 13'b0};
            end else if (he == 5'h1F) begin
               mid_in.special_val = {hs, 8'hFF, hm, 13'b0};
            end else begin
               mid_in.special_val = {hs, {3'b0, he} + 8'd112, hm, 13'b0};
            end
         end
         LK_UINT, LK_SINT: begin
            if (mag != 17'd0) begin
               mid_in.special = 1'b0;
               mid_in.ebase   = 8'd143;
               mid_in.frac    = {mag, 47'b0};
            end
         end
         LK_UNORM, LK_SNORM: begin
            if (mag == 17'd0) begin
               mid_in.special_val = FP_ZERO;
            end else if (mag == dmax) begin
               mid_in.special_val = neg ? FP_NEG_ONE : FP_ONE;
            end else if (mag > dmax) begin
               mid_in.special_val = FP_NEG_ONE;
            end else begin
               mid_in.special = 1'b0;
               mid_in.ebase   = 8'd126;
               mid_in.frac    = r;
            end
         end
         default: mid_in.special_val = lane_in.raw;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) mid_ff <= mid_in;
   end

   // step two: normalize and round to nearest (ties cannot occur)
   always_comb begin
      logic [4:0]  lz;
      logic [63:0] sh;
      logic [23:0] mant;
      logic [7:0]  expo;

      lz = 5'd16;
      for (int i = 0; i < 17; i++) begin
         if (mid_ff.frac[47 + i]) lz = 5'(16 - i);
      end
      sh   = mid_ff.frac << lz;
      mant = {1'b0, sh[62:40]} + {23'b0, sh[39]};
      expo = mid_ff.ebase - {3'b0, lz} + {7'b0, mant[23]};
      comp = mid_ff.special ? mid_ff.special_val : {mid_ff.neg, expo, mant[22:0]};
   end

endmodule
